// File: sv/ceu_pkg.sv
// ----------------------------------------------------------------------------
// Cache event counter unit package
// Operation codes, register offsets and the control group of a counter slice.
// ----------------------------------------------------------------------------
package ceu_pkg;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_EVENT = 2'd2,
        OP_NONE  = 2'd3
    } ceu_op_t;

    localparam int ADDR_W = 13;
    localparam int DATA_W = 64;
    localparam int SEL_W  = 8;
    localparam int VER_W  = 32;

    localparam logic [ADDR_W-1:0] ADDR_CTRL    = 13'h0408;
    localparam logic [ADDR_W-1:0] ADDR_MASK    = 13'h0800;
    localparam logic [ADDR_W-1:0] ADDR_STATUS  = 13'h0808;
    localparam logic [ADDR_W-1:0] ADDR_CLEAR   = 13'h080c;
    localparam logic [ADDR_W-1:0] ADDR_ENABLE  = 13'h1c00;
    localparam logic [ADDR_W-1:0] ADDR_VERSION = 13'h1cf0;
    localparam logic [ADDR_W-1:0] ADDR_SELECT  = 13'h1d00;
    localparam logic [ADDR_W-1:0] ADDR_COUNTER = 13'h1e00;

    localparam int CTRL_EN_BIT = 17;

    localparam logic [SEL_W-1:0] SEL_NONE = 8'hff;

    typedef struct packed {
        logic event_en;
        logic cnt_wr;
        logic sel_wr;
    } ceu_slice_ctrl_t;

endpackage

// File: sv/ceu_counter_slice.sv
// ----------------------------------------------------------------------------
// Cache event counter slice
// One event counter with its event select, match logic and wrap detection.
// ----------------------------------------------------------------------------
module ceu_counter_slice #(
    parameter int CNT_W = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ceu_pkg::ceu_slice_ctrl_t      ctrl,
    input  logic [CNT_W-1:0]              cnt_wdata,
    input  logic [ceu_pkg::SEL_W-1:0]     sel_wdata,
    input  logic [ceu_pkg::SEL_W-1:0]     event_code,
    output logic [CNT_W-1:0]              count,
    output logic [ceu_pkg::SEL_W-1:0]     select,
    output logic                          overflow
);

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [ceu_pkg::SEL_W-1:0] select_reg;
    logic [ceu_pkg::SEL_W-1:0] select_next;
    logic                      hit;

    assign hit = ctrl.event_en && (select_reg != ceu_pkg::SEL_NONE)
                 && (select_reg == event_code);

    always_comb begin
        count_next = count_reg;
        if (ctrl.cnt_wr) begin
            count_next = cnt_wdata;
        end else if (hit) begin
            count_next = count_reg + CNT_W'(1);
        end
        select_next = ctrl.sel_wr ? sel_wdata : select_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            select_reg <= ceu_pkg::SEL_NONE;
        end else begin
            count_reg  <= count_next;
            select_reg <= select_next;
        end
    end

    assign count    = count_reg;
    assign select   = select_reg;
    assign overflow = hit && (&count_reg);

endmodule

// File: sv/cache_event_counter_unit.sv
// ----------------------------------------------------------------------------
// Cache event counter unit
// Bus-mapped event counters for cache events, with overflow status and irq.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                      Direction
//   s_        s_op, s_addr, s_wdata, s_event_code        word in
//   m_        m_read_data, m_irq                         word out, one per input
//   cfg_      cfg_data (version register value)          word in
//
// Each word passes through an input register, then the register access or
// counter update, applied when the word moves into the output register. One
// word is accepted per cycle while the output side keeps taking results. A
// stall on m_ready holds the output register and then the input register.
// Reset is synchronous.
//
module cache_event_counter_unit #(
    parameter int N_CNT = 8,
    parameter int CNT_W = 48
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_op,
    input  logic [ceu_pkg::ADDR_W-1:0]    s_addr,
    input  logic [ceu_pkg::DATA_W-1:0]    s_wdata,
    input  logic [ceu_pkg::SEL_W-1:0]     s_event_code,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ceu_pkg::DATA_W-1:0]    m_read_data,
    output logic                          m_irq,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ceu_pkg::VER_W-1:0]     cfg_data
);

    localparam int SEL_REGS = (N_CNT + 3) / 4;

    logic                          in_valid_reg;
    logic [1:0]                    op_reg;
    logic [ceu_pkg::ADDR_W-1:0]    addr_reg;
    logic [ceu_pkg::DATA_W-1:0]    wdata_reg;
    logic [ceu_pkg::SEL_W-1:0]     code_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [ceu_pkg::DATA_W-1:0]    read_data_reg;
    logic [ceu_pkg::DATA_W-1:0]    read_data_next;
    logic                          irq_reg;
    logic                          irq_next;

    logic                          global_en_reg;
    logic                          global_en_next;
    logic [N_CNT-1:0]              mask_reg;
    logic [N_CNT-1:0]              mask_next;
    logic [N_CNT-1:0]              status_reg;
    logic [N_CNT-1:0]              status_next;
    logic [N_CNT-1:0]              enable_reg;
    logic [N_CNT-1:0]              enable_next;
    logic [ceu_pkg::VER_W-1:0]     version_reg;

    logic                          advance;
    logic                          is_read;
    logic                          is_write;
    logic                          is_event;
    logic                          sel_hit;
    logic                          cnt_hit;

    ceu_pkg::ceu_slice_ctrl_t      slice_ctrl [N_CNT];
    logic [CNT_W-1:0]              count      [N_CNT];
    logic [ceu_pkg::SEL_W-1:0]     select     [N_CNT];
    logic [N_CNT-1:0]              overflow;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= s_op;
            addr_reg  <= s_addr;
            wdata_reg <= s_wdata;
            code_reg  <= s_event_code;
        end
    end

    always_comb begin
        is_read  = 1'b0;
        is_write = 1'b0;
        is_event = 1'b0;
        unique case (ceu_pkg::ceu_op_t'(op_reg))
            ceu_pkg::OP_READ:  is_read  = 1'b1;
            ceu_pkg::OP_WRITE: is_write = 1'b1;
            ceu_pkg::OP_EVENT: is_event = 1'b1;
            ceu_pkg::OP_NONE:  ;
            default:           ;
        endcase
    end

    assign sel_hit = (addr_reg[12:3] == ceu_pkg::ADDR_SELECT[12:3]) && (addr_reg[1:0] == 2'b00)
                     && (32'(addr_reg[2]) < SEL_REGS);
    assign cnt_hit = (addr_reg[12:6] == ceu_pkg::ADDR_COUNTER[12:6])
                     && (addr_reg[2:0] == 3'b000) && (32'(addr_reg[5:3]) < N_CNT);

    genvar gi;
    generate
        for (gi = 0; gi < N_CNT; gi++) begin : g_slice
            assign slice_ctrl[gi].event_en = advance && is_event && global_en_reg
                                             && enable_reg[gi];
            assign slice_ctrl[gi].cnt_wr   = advance && is_write && cnt_hit
                                             && (addr_reg[5:3] == 3'(gi));
            assign slice_ctrl[gi].sel_wr   = advance && is_write && sel_hit
                                             && (addr_reg[2] == 1'(gi / 4));

            ceu_counter_slice #(
                .CNT_W (CNT_W)
            ) u_slice (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (slice_ctrl[gi]),
                .cnt_wdata  (wdata_reg[CNT_W-1:0]),
                .sel_wdata  (wdata_reg[8*(gi%4) +: 8]),
                .event_code (code_reg),
                .count      (count[gi]),
                .select     (select[gi]),
                .overflow   (overflow[gi])
            );
        end
    endgenerate

    always_comb begin
        global_en_next = global_en_reg;
        mask_next      = mask_reg;
        enable_next    = enable_reg;
        status_next    = status_reg | overflow;
        if (is_write) begin
            if (addr_reg == ceu_pkg::ADDR_CTRL) begin
                global_en_next = wdata_reg[ceu_pkg::CTRL_EN_BIT];
            end
            if (addr_reg == ceu_pkg::ADDR_MASK) begin
                mask_next = wdata_reg[N_CNT-1:0];
            end
            if (addr_reg == ceu_pkg::ADDR_ENABLE) begin
                enable_next = wdata_reg[N_CNT-1:0];
            end
            if (addr_reg == ceu_pkg::ADDR_CLEAR) begin
                status_next = status_reg & ~wdata_reg[N_CNT-1:0];
            end
        end
        irq_next = |(status_next & ~mask_next);
    end

    always_comb begin
        read_data_next = '0;
        if (is_read) begin
            if (addr_reg == ceu_pkg::ADDR_CTRL) begin
                read_data_next[ceu_pkg::CTRL_EN_BIT] = global_en_reg;
            end
            if (addr_reg == ceu_pkg::ADDR_MASK) begin
                read_data_next = ceu_pkg::DATA_W'(mask_reg);
            end
            if (addr_reg == ceu_pkg::ADDR_STATUS) begin
                read_data_next = ceu_pkg::DATA_W'(status_reg);
            end
            if (addr_reg == ceu_pkg::ADDR_ENABLE) begin
                read_data_next = ceu_pkg::DATA_W'(enable_reg);
            end
            if (addr_reg == ceu_pkg::ADDR_VERSION) begin
                read_data_next = ceu_pkg::DATA_W'(version_reg);
            end
            for (int i = 0; i < N_CNT; i++) begin
                if (sel_hit && (addr_reg[2] == 1'(i / 4))) begin
                    read_data_next = read_data_next
                                     | (ceu_pkg::DATA_W'(select[i]) << (8 * (i % 4)));
                end
                if (cnt_hit && (addr_reg[5:3] == 3'(i))) begin
                    read_data_next = read_data_next | ceu_pkg::DATA_W'(count[i]);
                end
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            global_en_reg <= 1'b0;
            mask_reg      <= '1;
            status_reg    <= '0;
            enable_reg    <= '0;
            version_reg   <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                global_en_reg <= global_en_next;
                mask_reg      <= mask_next;
                status_reg    <= status_next;
                enable_reg    <= enable_next;
            end
            if (cfg_valid && cfg_ready) begin
                version_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            read_data_reg <= read_data_next;
            irq_reg       <= irq_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_read_data = read_data_reg;
    assign m_irq       = irq_reg;

endmodule
